[src/stpf_pkg.sv]
// ----------------------------------------------------------------------------
// Spectrum top-four peak finder: shared definitions
// Widths, constants and the payload types passed between the front end, the
// frame queue and the result back end.
// ----------------------------------------------------------------------------
package stpf_pkg;

  // Frame geometry and number of ranked slots.
  localparam int FFT_SIZE_LOG2 = 10;
  localparam int PEAK_COUNT    = 4;

  // Field widths of the external payloads.
  localparam int MAG_W   = 16;
  localparam int RANK_W  = 2;
  localparam int BIN_W   = 10;
  localparam int FREQ_W  = 27;
  localparam int RATE_W  = 24;

  // Internal widths derived from the frame geometry.
  localparam int IDX_W   = FFT_SIZE_LOG2;
  localparam int CNT_W   = FFT_SIZE_LOG2 + 1;
  localparam int RCNT_W  = (PEAK_COUNT > 1) ? $clog2(PEAK_COUNT) : 1;
  localparam int PROD_W  = IDX_W + RATE_W;
  localparam int PROD10_W = PROD_W + 4;

  localparam logic [CNT_W-1:0]  FFT_SIZE      = CNT_W'(1) << FFT_SIZE_LOG2;
  localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(1000000);
  localparam logic [FREQ_W-1:0] FREQ_MAX      = '1;

  // Depth of the queue of finished frames.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One input bin.
  typedef struct packed {
    logic signed [MAG_W-1:0] magnitude_db;
    logic                    last_bin;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [BIN_W-1:0]  bin_index;
    logic [FREQ_W-1:0] freq_tenth_hz;
    logic              no_data;
    logic              last_result;
  } out_item_t;

  // Summary of one finished frame: ranked bin indices, empty slots as zero.
  typedef struct packed {
    logic                              no_data;
    logic [PEAK_COUNT-1:0][IDX_W-1:0]  idx;
  } frame_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/spectrum_top4_peak_finder_unit.sv]
// ----------------------------------------------------------------------------
// Spectrum top-four peak finder
// Streaming selection of the four largest bins of each spectrum frame.
// ----------------------------------------------------------------------------
// One magnitude bin is taken per clock cycle, with no gaps between frames;
// the bin position is counted internally, the DC bin and bins beyond the FFT
// size are skipped, and the four ranked slots are updated by four parallel
// comparators in the cycle the bin is taken. On the last bin a frame summary
// enters a two-entry queue, and the back end delivers its results one per
// cycle while the receiver is ready (four per frame, or a single no-data
// result for a frame of two bins or fewer), each through the multiply and
// output registers. Bin intake stalls only while the queue holds two
// undelivered frames, so a sustained rate of one bin per cycle is kept for
// frames of four bins or more with an always-ready receiver. The frequency
// path is one 10 x 24 bit multiplier followed by a scale by ten and a shift.
// ----------------------------------------------------------------------------
module spectrum_top4_peak_finder_unit import stpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  q_stat_t q_stat;
  logic    push;
  frame_t  push_data;
  logic    pop;
  frame_t  head;

  // Bin intake and slot ranking.
  stpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of finished frames.
  stpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Result generation and delivery.
  stpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/stpf_front.sv]
// ----------------------------------------------------------------------------
// Peak finder front end
// Counts bins, inserts each in-range bin into the ranked slots in the cycle
// it is taken and hands a frame summary to the queue on the last bin.
// ----------------------------------------------------------------------------
module stpf_front import stpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output frame_t   push_data
);

  logic signed [MAG_W-1:0] mag [PEAK_COUNT];
  logic [IDX_W-1:0]        idx [PEAK_COUNT];
  logic [PEAK_COUNT-1:0]   valid;
  logic [CNT_W-1:0]        bin_counter;

  logic signed [MAG_W-1:0] mag_next [PEAK_COUNT];
  logic [IDX_W-1:0]        idx_next [PEAK_COUNT];
  logic [PEAK_COUNT-1:0]   valid_next;
  logic signed [MAG_W-1:0] mag_up [PEAK_COUNT];
  logic [IDX_W-1:0]        idx_up [PEAK_COUNT];
  logic [PEAK_COUNT-1:0]   valid_up;
  logic [PEAK_COUNT-1:0]   cond;
  logic [PEAK_COUNT-1:0]   first;
  logic                    accept;
  logic                    do_ins;

  // A bin is taken whenever the queue has room for a frame summary.
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign do_ins   = (bin_counter != '0) && (bin_counter < FFT_SIZE);

  // Insertion: the slots are sorted, so the slots that lose to the new bin
  // form a tail; the first of them takes the bin and the rest shift down.
  always_comb begin
    mag_up[0]   = in_data.magnitude_db;
    idx_up[0]   = bin_counter[IDX_W-1:0];
    valid_up[0] = 1'b1;
    for (int j = 1; j < PEAK_COUNT; j++) begin
      mag_up[j]   = mag[j-1];
      idx_up[j]   = idx[j-1];
      valid_up[j] = valid[j-1];
    end
    for (int j = 0; j < PEAK_COUNT; j++) begin
      cond[j] = !valid[j] || (in_data.magnitude_db > mag[j]);
    end
    first = cond & ~(cond << 1);
    for (int j = 0; j < PEAK_COUNT; j++) begin
      if (do_ins && first[j]) begin
        mag_next[j]   = in_data.magnitude_db;
        idx_next[j]   = bin_counter[IDX_W-1:0];
        valid_next[j] = 1'b1;
      end else if (do_ins && cond[j]) begin
        mag_next[j]   = mag_up[j];
        idx_next[j]   = idx_up[j];
        valid_next[j] = valid_up[j];
      end else begin
        mag_next[j]   = mag[j];
        idx_next[j]   = idx[j];
        valid_next[j] = valid[j];
      end
    end
  end

  // Frame summary taken from the slots as they stand after the last bin.
  always_comb begin
    push              = accept && in_data.last_bin;
    push_data.no_data = (bin_counter <= CNT_W'(1));
    for (int j = 0; j < PEAK_COUNT; j++) begin
      push_data.idx[j] = valid_next[j] ? idx_next[j] : '0;
    end
  end

  // Slot payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < PEAK_COUNT; j++) begin
        mag[j] <= mag_next[j];
        idx[j] <= idx_next[j];
      end
    end
  end

  // Slot valid bits and bin counter, cleared at the end of each frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      bin_counter <= '0;
    end else if (accept) begin
      if (in_data.last_bin) begin
        valid       <= '0;
        bin_counter <= '0;
      end else begin
        valid <= valid_next;
        if (bin_counter < FFT_SIZE) begin
          bin_counter <= bin_counter + CNT_W'(1);
        end
      end
    end
  end

endmodule

[src/stpf_queue.sv]
// ----------------------------------------------------------------------------
// Peak finder frame queue
// A short first-in first-out store of frame summaries that decouples the
// bin intake from result delivery.
// ----------------------------------------------------------------------------
module stpf_queue import stpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  frame_t  push_data,
  input  logic    pop,
  output frame_t  head,
  output q_stat_t q_stat
);

  frame_t              store [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/stpf_back.sv]
// ----------------------------------------------------------------------------
// Peak finder result back end
// Walks a frame summary rank by rank, converts each bin index to a frequency
// in a two-stage pipeline and holds the result in an output register.
// ----------------------------------------------------------------------------
module stpf_back import stpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  input  frame_t            head,
  input  q_stat_t           q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic [RATE_W-1:0]   sample_rate;
  logic [RCNT_W-1:0]   rank_cnt;

  // Issue stage signals.
  logic                issue;
  logic [IDX_W-1:0]    iss_idx;
  logic                iss_last;

  // Multiply stage registers.
  logic                s1_valid;
  logic [RCNT_W-1:0]   s1_rank;
  logic [IDX_W-1:0]    s1_idx;
  logic                s1_no_data;
  logic                s1_last;
  logic [PROD_W-1:0]   s1_prod;
  logic                s1_ready;
  logic                out_free;

  logic [PROD10_W-1:0] prod10;
  logic [PROD10_W-1:0] freq_full;
  logic [FREQ_W-1:0]   freq_sat;

  // Sample rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RATE_RESET;
    end else if (cfg_we) begin
      sample_rate <= cfg_wdata;
    end
  end

  // Issue: one rank per cycle, while the multiply stage can take it, from the frame at the head of the queue.
  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign issue    = !q_stat.empty && s1_ready;
  assign iss_idx  = head.no_data ? '0 : head.idx[rank_cnt];
  assign iss_last = head.no_data || (rank_cnt == RCNT_W'(PEAK_COUNT - 1));
  assign pop      = issue && iss_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_cnt <= '0;
    end else if (issue) begin
      rank_cnt <= iss_last ? '0 : rank_cnt + RCNT_W'(1);
    end
  end

  // Multiply stage: bin index times sample rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_rank    <= rank_cnt;
      s1_idx     <= iss_idx;
      s1_no_data <= head.no_data;
      s1_last    <= iss_last;
      s1_prod    <= PROD_W'(iss_idx) * PROD_W'(sample_rate);
    end
  end

  // Scale by ten, divide by the FFT size and saturate.
  always_comb begin
    prod10    = (PROD10_W'(s1_prod) << 3) + (PROD10_W'(s1_prod) << 1);
    freq_full = prod10 >> FFT_SIZE_LOG2;
    freq_sat  = (freq_full > PROD10_W'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(freq_full);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data.rank          <= RANK_W'(s1_rank);
      out_data.bin_index     <= BIN_W'(s1_idx);
      out_data.freq_tenth_hz <= freq_sat;
      out_data.no_data       <= s1_no_data;
      out_data.last_result   <= s1_last;
    end
  end

endmodule

[src/stpf_checker.sv]
// ----------------------------------------------------------------------------
// Peak finder port checker
// Checks the result stream seen at the top-level ports.
// ----------------------------------------------------------------------------
module stpf_checker import stpf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result stays on offer unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A no-data result is the single, rank-zero, empty result of its frame.
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_data |->
      out_data.last_result && (out_data.rank == '0) && (out_data.bin_index == '0))
    else $error("malformed no-data result");

  // Only the final rank closes a normal frame.
  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.no_data |->
      (out_data.last_result == (out_data.rank == RANK_W'(PEAK_COUNT - 1))))
    else $error("frame end marker on the wrong rank");

  // An empty slot or bin zero reports zero frequency.
  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.bin_index == '0) |-> (out_data.freq_tenth_hz == '0))
    else $error("non-zero frequency for bin zero");

endmodule

bind spectrum_top4_peak_finder_unit stpf_checker u_stpf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
